FILE: sv/fcw_pkg.sv
// Shared types and constants for the allocation-table chain walker.
// No dependencies; every other file in sv/ but fcw_ram refers to this package by scoped names.
`default_nettype none

package fcw_pkg;

  // Default table depth and command queue depth
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int QUEUE_DEPTH       = 2;

  // Input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_READ    = 2'd0;
  localparam logic [1:0] ST_NO_WALK = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DATA_BASE = 2'd0;
  localparam logic [1:0] CFG_SPC       = 2'd1;
  localparam logic [1:0] CFG_FAT32     = 2'd2;

  // End-of-chain markers and sector geometry
  localparam logic [31:0] FAT16_END    = 32'h0000_fff8;
  localparam logic [31:0] FAT32_END    = 32'h0fff_fff8;
  localparam logic [32:0] SECTOR_ROUND = 33'd511;
  localparam logic [7:0]  SPC_MAX      = 8'd128;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] entry_index;
    logic [31:0] entry_value;
    logic [27:0] start_cluster;
    logic [31:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] read_address;
    logic [7:0]  sector_count;
    logic        last_command;
  } out_item_t;

  // Classified command handed from front to back
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_START,
    KIND_NEXT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] index;    // table slot for writes
    logic [27:0] cluster;  // first cluster for starts
    logic [31:0] data;     // entry value for writes, byte count for starts
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/fcw_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module fcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/fcw_front.sv
// Front end: accepts input items, decodes the opcode and drops items with no effect.
// Depends on fcw_pkg.
`default_nettype none

module fcw_front #(
  parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fcw_pkg::in_item_t in_data,
  output logic                  push,
  output fcw_pkg::cmd_t         push_cmd,
  input  wire logic             q_full
);

  localparam logic [27:0] TableLimit = 28'(TABLE_ENTRIES);

  logic          cmd_valid_r, cmd_valid_nxt;
  fcw_pkg::cmd_t cmd_r, cmd_nxt;
  logic          accept;
  logic          keep;
  fcw_pkg::cmd_t dec_cmd;

  // Decode: opcode 3 and writes past the table end are dropped
  always_comb begin
    keep          = 1'b0;
    dec_cmd.kind  = fcw_pkg::KIND_NEXT;
    dec_cmd.index = in_data.entry_index;
    dec_cmd.cluster = in_data.start_cluster;
    dec_cmd.data  = in_data.byte_count;
    unique case (in_data.opcode)
      fcw_pkg::OP_WRITE: begin
        dec_cmd.kind = fcw_pkg::KIND_WRITE;
        dec_cmd.data = in_data.entry_value;
        keep         = ({16'd0, in_data.entry_index} < TableLimit);
      end
      fcw_pkg::OP_START: begin
        dec_cmd.kind = fcw_pkg::KIND_START;
        keep         = 1'b1;
      end
      fcw_pkg::OP_NEXT: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Stage register ahead of the queue
  assign push     = cmd_valid_r && !q_full;
  assign in_stall = cmd_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = cmd_r;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    cmd_nxt       = cmd_r;
    if (push) begin
      cmd_valid_nxt = 1'b0;
    end
    if (accept && keep) begin
      cmd_valid_nxt = 1'b1;
      cmd_nxt       = dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/fcw_queue.sv
// Short command queue between front end and back end.
// Depends on fcw_pkg (command type and depth).
`default_nettype none

module fcw_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fcw_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output fcw_pkg::cmd_t      pop_cmd,
  output logic               not_empty
);

  localparam int QDepth = fcw_pkg::QUEUE_DEPTH;
  localparam int PtrW   = $clog2(QDepth);
  localparam logic [PtrW:0] CountFull = (PtrW + 1)'(QDepth);

  fcw_pkg::cmd_t   slot_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]   count_r, count_nxt;

  assign full      = (count_r == CountFull);
  assign not_empty = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  // Pointers wrap naturally; depth is a power of two
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

FILE: sv/fcw_back.sv
// Back end: table store, walk state, configuration registers and result register.
// Depends on fcw_pkg and fcw_ram.
`default_nettype none

module fcw_back #(
  parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire fcw_pkg::cmd_t     q_cmd,
  output logic                   q_pop,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [47:0]       cfg_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fcw_pkg::out_item_t     out_data
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [27:0] TableLimit = 28'(TABLE_ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t             state_r, state_nxt;
  logic [27:0]        cur_r, cur_nxt;
  logic [31:0]        left_r, left_nxt;
  logic               active_r, active_nxt;
  logic [35:0]        prod_r, prod_nxt;
  logic [47:0]        base_r, base_nxt;
  logic [7:0]         spc_r, spc_nxt;
  logic               fat32_r, fat32_nxt;
  logic               out_valid_r, out_valid_nxt;
  fcw_pkg::out_item_t out_r, out_nxt;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_addr;
  logic [31:0]     ram_rdata;

  logic        out_free;
  logic [7:0]  spc_eff;
  logic [31:0] clus_bytes;
  logic [27:0] issue_cluster;
  logic [27:0] clus_m2;
  logic        in_range;
  logic        fits;
  logic [32:0] secs_sum;
  logic [47:0] addr;
  logic        is_end;

  fcw_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(q_cmd.data),
    .rdata(ram_rdata)
  );

  // Cluster size clamps to 1..128 sectors
  always_comb begin
    if (spc_r == 8'd0) begin
      spc_eff = 8'd1;
    end else if (spc_r > fcw_pkg::SPC_MAX) begin
      spc_eff = fcw_pkg::SPC_MAX;
    end else begin
      spc_eff = spc_r;
    end
  end

  assign clus_bytes    = {15'd0, spc_eff, 9'd0};
  assign out_free      = !out_valid_r || !out_stall;
  assign issue_cluster = (q_cmd.kind == fcw_pkg::KIND_START) ? q_cmd.cluster : cur_r;
  assign clus_m2       = issue_cluster - 28'd2;

  // Command forming, uses the product and table entry registered when the command was issued
  assign in_range = (cur_r >= 28'd2) && (cur_r < TableLimit);
  assign fits     = (left_r <= clus_bytes);
  assign secs_sum = {1'b0, left_r} + fcw_pkg::SECTOR_ROUND;
  assign addr     = base_r + {3'd0, prod_r, 9'd0};
  assign is_end   = ram_rdata >= (fat32_r ? fcw_pkg::FAT32_END : fcw_pkg::FAT16_END);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    active_nxt    = active_r;
    prod_nxt      = prod_r;
    base_nxt      = base_r;
    spc_nxt       = spc_r;
    fat32_nxt     = fat32_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = issue_cluster[IdxW-1:0];

    // Configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        fcw_pkg::CFG_DATA_BASE: base_nxt  = cfg_data;
        fcw_pkg::CFG_SPC:       spc_nxt   = cfg_data[7:0];
        fcw_pkg::CFG_FAT32:     fat32_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            fcw_pkg::KIND_WRITE: begin
              q_pop    = 1'b1;
              ram_we   = 1'b1;
              ram_addr = IdxW'(q_cmd.index);
            end
            fcw_pkg::KIND_START: begin
              q_pop      = 1'b1;
              ram_re     = 1'b1;
              cur_nxt    = q_cmd.cluster;
              left_nxt   = q_cmd.data;
              active_nxt = 1'b1;
              prod_nxt   = 36'(clus_m2) * 36'(spc_eff);
              state_nxt  = S_CALC;
            end
            default: begin
              if (active_r) begin
                q_pop     = 1'b1;
                ram_re    = 1'b1;
                prod_nxt  = 36'(clus_m2) * 36'(spc_eff);
                state_nxt = S_CALC;
              end else if (out_free) begin
                // Next without a walk
                q_pop                = 1'b1;
                out_valid_nxt        = 1'b1;
                out_nxt.status       = fcw_pkg::ST_NO_WALK;
                out_nxt.read_address = '0;
                out_nxt.sector_count = '0;
                out_nxt.last_command = 1'b0;
              end
            end
          endcase
        end
      end
      S_CALC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (!in_range) begin
            active_nxt           = 1'b0;
            out_nxt.status       = fcw_pkg::ST_BAD;
            out_nxt.read_address = '0;
            out_nxt.sector_count = '0;
            out_nxt.last_command = 1'b0;
          end else if (fits) begin
            // Final command: remaining bytes rounded up to sectors
            active_nxt           = 1'b0;
            out_nxt.status       = fcw_pkg::ST_READ;
            out_nxt.read_address = addr;
            out_nxt.sector_count = secs_sum[16:9];
            out_nxt.last_command = 1'b1;
          end else begin
            // Full cluster, follow the chain unless an end marker is hit
            left_nxt             = left_r - clus_bytes;
            out_nxt.status       = fcw_pkg::ST_READ;
            out_nxt.read_address = addr;
            out_nxt.sector_count = spc_eff;
            out_nxt.last_command = is_end;
            if (is_end) begin
              active_nxt = 1'b0;
            end else begin
              cur_nxt = ram_rdata[27:0];
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      left_r      <= '0;
      active_r    <= 1'b0;
      base_r      <= '0;
      spc_r       <= 8'd1;
      fat32_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      left_r      <= left_nxt;
      active_r    <= active_nxt;
      base_r      <= base_nxt;
      spc_r       <= spc_nxt;
      fat32_r     <= fat32_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table written and read in one cycle");
  a_calc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (state_nxt == S_CALC) |-> ram_re)
    else $error("command forming without a table read");
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != fcw_pkg::ST_READ) |->
      (out_r.read_address == '0) && (out_r.sector_count == '0) && !out_r.last_command)
    else $error("status result with nonzero fields");
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == fcw_pkg::ST_READ) |->
      (out_r.sector_count <= fcw_pkg::SPC_MAX) &&
      ((out_r.sector_count != '0) || out_r.last_command))
    else $error("read command with bad sector count");
`endif

endmodule

`default_nettype wire

FILE: sv/fat_cluster_chain_walker.sv
// Allocation-table chain walker, FAT16/FAT32, turns cluster chains into
// block-read commands.
//
// Input channel (in_valid / in_stall / in_data): write items load one table
// entry each and give no result; a start item begins a walk and gives a read
// command or a bad-cluster status; each next item does likewise, or gives a
// no-walk status. Opcode 3 and writes past the table end are taken and dropped.
// Result channel (out_valid / out_stall / out_data): one item per start or
// next item, in order. A stalled result holds in the output register while
// further items are taken into the input stage and a two-entry queue.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while the block is idle.
// Back end: a write item retires with its table write; a start or next item goes
// through a table read of the current cluster, then address add and command
// forming. The back end takes no new command from the queue until the one in
// progress has formed its result; the table has a single port. Reset clears
// walk state and config (base 0, 1 sector, FAT16); the table is not cleared
// and must be written before it is walked.
// Depends on fcw_pkg, fcw_front, fcw_queue, fcw_back, fcw_ram.
`default_nettype none

module fat_cluster_chain_walker #(
  parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fcw_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fcw_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);

  logic          push;
  fcw_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          q_pop;
  fcw_pkg::cmd_t q_cmd;
  logic          q_valid;

  assign cfg_ready = 1'b1;

  fcw_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .push    (push),
    .push_cmd(push_cmd),
    .q_full  (q_full)
  );

  fcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .not_empty(q_valid)
  );

  fcw_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
